// ----- sv/fasp_pkg.sv -----
// Shared constants and types for the file access stride predictor.
package fasp_pkg;

	// default parameter values
	localparam int BITMAP_PORTIONS_DEF    = 4096;
	localparam int MAX_LOOKBACK_DEF       = 8;
	localparam int PAGE_BYTES_LOG2_DEF    = 12;
	localparam int PORTION_PAGES_LOG2_DEF = 4;

	// payload widths
	localparam int OFF_W    = 40;
	localparam int LEN_W    = 32;
	localparam int SCORE_W  = 6;
	localparam int SPAGES_W = 7;
	localparam int STAT_W   = 2;

	// bitmap row geometry
	localparam int WORD_W    = 32;
	localparam int WORD_LOG2 = 5;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;
	localparam int PCNT_W     = 13;
	localparam int DEPTH_W    = 4;
	localparam int SMIN_W     = 5;
	localparam int SMAX_W     = 5;
	localparam int SSTART_W   = 6;

	localparam logic [CFG_IDX_W-1:0] REG_PORTION_COUNT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOOKBACK_DEPTH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCORE_MIN      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCORE_MAX      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SCORE_START    = 3'd4;

	localparam logic [PCNT_W-1:0]   PCNT_RST   = 13'd4096;
	localparam logic [DEPTH_W-1:0]  DEPTH_RST  = 4'd8;
	localparam logic [SMIN_W-1:0]   SMIN_RST   = 5'b11100;
	localparam logic [SMAX_W-1:0]   SMAX_RST   = 5'd4;
	localparam logic [SSTART_W-1:0] SSTART_RST = 6'd0;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_ADJ   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NOADJ = 2'd1;
	localparam logic [STAT_W-1:0] STAT_START = 2'd2;
	localparam logic [STAT_W-1:0] STAT_OOR   = 2'd3;

	// bitmap access strobes
	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} bm_ctl_t;

endpackage

// ----- sv/file_access_stride_predictor_top.sv -----
// Top level of the file access stride predictor.
// Usage:
//   Input channel (in_valid / in_stall): one read request per item, byte_offset and
//   byte_length. in_stall is high while an item is being worked on, during the
//   clearing pass after reset, and while a finished result waits for the output
//   register to free up.
//   Output channel (out_valid / out_stall): one result per item (score,
//   stride_pages, strided_length, status) held in an output register; a stalled
//   result holds still, and the next item can be accepted while it waits.
//   Config channel (cfg_valid / cfg_ready): register index and data, always ready;
//   write only while idle. Writing score_start also reloads the score.
// Sequencing:
//   A sequencer steps one shared add/subtract unit and the single-port bitmap.
//   After accept: range check, end of marked run, read + write of each row of 32
//   portions in the run, lookback probes (address + bit test each, up to
//   min(lookback_depth, MAX_LOOKBACK), one more step if none hits), score update and
//   result load. Out of range and start skip to the load; next item the cycle after.
// Reset:
//   Asynchronous, active low. Registers load their reset values, then the bitmap
//   is cleared one row a cycle, all BITMAP_PORTIONS/32 rows (rounded up to a power
//   of two, 128 at the default size); no item is accepted during the clear.
module file_access_stride_predictor_top #(
	parameter int BITMAP_PORTIONS    = fasp_pkg::BITMAP_PORTIONS_DEF,
	parameter int MAX_LOOKBACK       = fasp_pkg::MAX_LOOKBACK_DEF,
	parameter int PAGE_BYTES_LOG2    = fasp_pkg::PAGE_BYTES_LOG2_DEF,
	parameter int PORTION_PAGES_LOG2 = fasp_pkg::PORTION_PAGES_LOG2_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// request channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [fasp_pkg::OFF_W-1:0]        byte_offset,
	input  logic [fasp_pkg::LEN_W-1:0]        byte_length,
	// result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [fasp_pkg::SCORE_W-1:0] score,
	output logic [fasp_pkg::SPAGES_W-1:0]     stride_pages,
	output logic [fasp_pkg::LEN_W-1:0]        strided_length,
	output logic [fasp_pkg::STAT_W-1:0]       status,
	// configuration channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [fasp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fasp_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import fasp_pkg::*;

	localparam int SHIFT = PAGE_BYTES_LOG2 + PORTION_PAGES_LOG2;
	localparam int PW    = OFF_W - SHIFT;                 // first portion, raw
	localparam int NW    = LEN_W - SHIFT;                 // portion count
	localparam int PAW   = $clog2(BITMAP_PORTIONS);        // in-bitmap portion index
	localparam int RAW   = PAW - WORD_LOG2;                // bitmap row index
	localparam int LWB   = $clog2(BITMAP_PORTIONS + 1);
	localparam int LW    = (LWB > PCNT_W) ? LWB : PCNT_W;  // limit width
	localparam int AW    = (PW > LW) ? PW : LW;            // shared unit width
	localparam int KWB   = $clog2(MAX_LOOKBACK + 2);
	localparam int CW    = ((KWB > DEPTH_W) ? KWB : DEPTH_W) + 1;
	localparam int SWB   = $clog2(MAX_LOOKBACK);
	localparam int SW    = (SWB > 0) ? SWB : 1;

	// sequencer states
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RNG  = 4'd1;  // range check
	localparam logic [3:0] S_LAST = 4'd2;  // end of marked run
	localparam logic [3:0] S_MRD  = 4'd3;  // mark: read row
	localparam logic [3:0] S_MWR  = 4'd4;  // mark: write row
	localparam logic [3:0] S_LREQ = 4'd5;  // lookback: probe address
	localparam logic [3:0] S_LCHK = 4'd6;  // lookback: test bit
	localparam logic [3:0] S_UPD  = 4'd7;  // score update
	localparam logic [3:0] S_DONE = 4'd8;  // hand result to output register

	logic [3:0]            state_q;

	// config registers
	logic [PCNT_W-1:0]     portion_count_q;
	logic [DEPTH_W-1:0]    lookback_depth_q;
	logic [SMIN_W-1:0]     score_min_q;
	logic [SMAX_W-1:0]     score_max_q;

	// predictor state
	logic signed [SCORE_W-1:0] seq_score_q;
	logic [SW-1:0]         stride_q;
	logic [LEN_W-1:0]      strided_len_q;

	// per-item working registers
	logic [PW-1:0]         p_raw_q;
	logic [NW-1:0]         n_q;
	logic [LEN_W-1:0]      len_q;
	logic [PAW-1:0]        p_q;
	logic [PAW-1:0]        last_q;
	logic [RAW-1:0]        row_q;
	logic [CW-1:0]         k_q;
	logic [WORD_LOG2-1:0]  bitpos_q;
	logic [STAT_W-1:0]     stat_q;

	// output register
	logic                  out_valid_q;
	logic signed [SCORE_W-1:0] score_q;
	logic [SPAGES_W-1:0]   spages_q;
	logic [LEN_W-1:0]      slen_q;
	logic [STAT_W-1:0]     status_q;

	// shared add/subtract unit
	logic [AW-1:0]         alu_a;
	logic [AW-1:0]         alu_b;
	logic                  alu_sub;
	logic [AW:0]           alu_res;
	logic                  alu_ge;

	logic [LW-1:0]         limit;
	logic [LW-1:0]         lim_m1;
	logic [CW-1:0]         depth;
	logic [CW-1:0]         depth_ext;
	logic [CW-1:0]         max_lb;
	logic                  in_acc;
	logic                  out_free;
	logic                  run_end;

	// bitmap port
	bm_ctl_t               bm_ctl;
	logic [RAW-1:0]        bm_addr;
	logic [WORD_W-1:0]     bm_wdata;
	logic [WORD_W-1:0]     bm_rdata;
	logic                  bm_busy;
	logic [WORD_LOG2-1:0]  mask_lo;
	logic [WORD_LOG2-1:0]  mask_hi;
	logic [WORD_W-1:0]     mask;

	// score saturation
	logic signed [SCORE_W:0] sc_inc;
	logic signed [SCORE_W:0] sc_dec;
	logic signed [SCORE_W:0] sc_max;
	logic signed [SCORE_W:0] sc_min;
	logic signed [SCORE_W:0] sc_next;

	logic [SW+PORTION_PAGES_LOG2+SPAGES_W-1:0] spages_wide;

	fasp_bitmap #(
		.ROW_AW (RAW)
	) u_bitmap (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (bm_ctl),
		.addr   (bm_addr),
		.wdata  (bm_wdata),
		.rdata  (bm_rdata),
		.busy   (bm_busy)
	);

	// effective limit and depth
	always_comb begin
		limit     = (LW'(portion_count_q) < LW'(BITMAP_PORTIONS)) ?
			LW'(portion_count_q) : LW'(BITMAP_PORTIONS);
		lim_m1    = limit - 1'b1;
		depth_ext = CW'(lookback_depth_q);
		max_lb    = CW'(MAX_LOOKBACK);
		depth     = (depth_ext > max_lb) ? max_lb : depth_ext;
	end

	// operand select for the shared unit
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		unique case (state_q)
			S_RNG: begin
				alu_a   = AW'(p_raw_q);
				alu_b   = AW'(limit);
				alu_sub = 1'b1;
			end
			S_LAST: begin
				alu_a = AW'(p_q);
				alu_b = AW'(n_q);
			end
			S_LREQ: begin
				alu_a   = AW'(p_q);
				alu_b   = AW'(k_q);
				alu_sub = 1'b1;
			end
			default: begin
			end
		endcase
		alu_res = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (AW + 1)'(alu_sub);
		alu_ge  = alu_res[AW];  // carry out: a >= b on subtract
	end

	// row mask for the marked run
	always_comb begin
		mask_lo = (row_q == p_q[PAW-1:WORD_LOG2]) ? p_q[WORD_LOG2-1:0] : '0;
		mask_hi = (row_q == last_q[PAW-1:WORD_LOG2]) ? last_q[WORD_LOG2-1:0] : '1;
		mask    = ({WORD_W{1'b1}} << mask_lo) & ({WORD_W{1'b1}} >> (~mask_hi));
		run_end = (row_q == last_q[PAW-1:WORD_LOG2]);
	end

	// bitmap port drive
	always_comb begin
		bm_ctl.rd_en = (state_q == S_MRD) ||
			((state_q == S_LREQ) && (k_q <= depth) && alu_ge);
		bm_ctl.wr_en = (state_q == S_MWR);
		bm_addr      = (state_q == S_LREQ) ? alu_res[PAW-1:WORD_LOG2] : row_q;
		bm_wdata     = bm_rdata | mask;
	end

	// saturating score step; limits are applied as written, even if inverted
	always_comb begin
		sc_inc  = {seq_score_q[SCORE_W-1], seq_score_q} + 1'sb1;
		sc_dec  = {seq_score_q[SCORE_W-1], seq_score_q} - 1'sb1;
		sc_max  = $signed({2'b00, score_max_q});
		sc_min  = $signed({{2{score_min_q[SMIN_W-1]}}, score_min_q});
		sc_next = {seq_score_q[SCORE_W-1], seq_score_q};
		if (stat_q == STAT_ADJ) begin
			sc_next = (sc_inc < sc_max) ? sc_inc : sc_max;
		end else if (stat_q == STAT_NOADJ) begin
			sc_next = (sc_dec > sc_min) ? sc_dec : sc_min;
		end
	end

	assign spages_wide = (SW + PORTION_PAGES_LOG2 + SPAGES_W)'(stride_q) << PORTION_PAGES_LOG2;

	assign out_free = !out_valid_q || !out_stall;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			portion_count_q  <= PCNT_RST;
			lookback_depth_q <= DEPTH_RST;
			score_min_q      <= SMIN_RST;
			score_max_q      <= SMAX_RST;
			seq_score_q      <= $signed(SSTART_RST);
			stride_q         <= '0;
			strided_len_q    <= '0;
			out_valid_q      <= 1'b0;
			p_raw_q          <= '0;
			n_q              <= '0;
			len_q            <= '0;
			p_q              <= '0;
			last_q           <= '0;
			row_q            <= '0;
			k_q              <= '0;
			bitpos_q         <= '0;
			stat_q           <= STAT_OOR;
			score_q          <= '0;
			spages_q         <= '0;
			slen_q           <= '0;
			status_q         <= STAT_OOR;
		end else begin
			// the done step reloads the output register itself
			if (out_valid_q && !out_stall && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						p_raw_q <= byte_offset[OFF_W-1:SHIFT];
						n_q     <= byte_length[LEN_W-1:SHIFT];
						len_q   <= byte_length;
						state_q <= S_RNG;
					end
				end
				S_RNG: begin
					if (alu_ge) begin
						stat_q  <= STAT_OOR;
						state_q <= S_DONE;
					end else begin
						p_q     <= p_raw_q[PAW-1:0];
						state_q <= S_LAST;
					end
				end
				S_LAST: begin
					// clamp the run at the last valid portion
					if (alu_res > (AW + 1)'(lim_m1)) begin
						last_q <= lim_m1[PAW-1:0];
					end else begin
						last_q <= alu_res[PAW-1:0];
					end
					row_q   <= p_q[PAW-1:WORD_LOG2];
					state_q <= S_MRD;
				end
				S_MRD: begin
					state_q <= S_MWR;
				end
				S_MWR: begin
					if (run_end) begin
						k_q     <= CW'(1);
						state_q <= S_LREQ;
					end else begin
						row_q   <= row_q + 1'b1;
						state_q <= S_MRD;
					end
				end
				S_LREQ: begin
					if (k_q > depth) begin
						stat_q  <= STAT_NOADJ;
						state_q <= S_UPD;
					end else if (!alu_ge) begin
						// lookback ran below portion zero
						stat_q  <= STAT_START;
						state_q <= S_DONE;
					end else begin
						bitpos_q <= alu_res[WORD_LOG2-1:0];
						state_q  <= S_LCHK;
					end
				end
				S_LCHK: begin
					if (bm_rdata[bitpos_q]) begin
						stride_q <= SW'(k_q - 1'b1);
						if (k_q != CW'(1)) begin
							strided_len_q <= len_q;
						end
						stat_q  <= STAT_ADJ;
						state_q <= S_UPD;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_LREQ;
					end
				end
				S_UPD: begin
					seq_score_q <= sc_next[SCORE_W-1:0];
					state_q     <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						score_q     <= seq_score_q;
						spages_q    <= spages_wide[SPAGES_W-1:0];
						slen_q      <= strided_len_q;
						status_q    <= stat_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// the user must send config writes only while idle; the block itself does not enforce it
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_PORTION_COUNT:  portion_count_q  <= cfg_data[PCNT_W-1:0];
					REG_LOOKBACK_DEPTH: lookback_depth_q <= cfg_data[DEPTH_W-1:0];
					REG_SCORE_MIN:      score_min_q      <= cfg_data[SMIN_W-1:0];
					REG_SCORE_MAX:      score_max_q      <= cfg_data[SMAX_W-1:0];
					REG_SCORE_START: begin
						seq_score_q <= $signed(cfg_data[SSTART_W-1:0]);
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign in_stall       = (state_q != S_IDLE) || bm_busy;
	assign cfg_ready      = 1'b1;
	assign out_valid      = out_valid_q;
	assign score          = score_q;
	assign stride_pages   = spages_q;
	assign strided_length = slen_q;
	assign status         = status_q;

endmodule

// ----- sv/fasp_bitmap.sv -----
// Visited-portion bitmap: one-port row memory with a clearing pass after reset.
module fasp_bitmap #(
	parameter int ROW_AW = 7
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fasp_pkg::bm_ctl_t             ctl,
	input  logic [ROW_AW-1:0]             addr,
	input  logic [fasp_pkg::WORD_W-1:0]   wdata,
	output logic [fasp_pkg::WORD_W-1:0]   rdata,
	output logic                          busy
);
	import fasp_pkg::*;

	localparam int ROWS = 1 << ROW_AW;

	logic [WORD_W-1:0] mem [ROWS];
	logic [ROW_AW-1:0] clr_row_q;
	logic              busy_q;
	logic              wr_en;
	logic [ROW_AW-1:0] wr_addr;
	logic [WORD_W-1:0] wr_data;

	// clearing pass owns the write port until every row is zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_row_q <= '0;
			busy_q    <= 1'b1;
		end else if (busy_q) begin
			clr_row_q <= clr_row_q + 1'b1;
			if (clr_row_q == {ROW_AW{1'b1}}) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_comb begin
		wr_en   = busy_q | ctl.wr_en;
		wr_addr = busy_q ? clr_row_q : addr;
		wr_data = busy_q ? '0 : wdata;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rdata <= mem[addr];
		end
	end

	assign busy = busy_q;

endmodule

// ----- sv/fasp_checker.sv -----
// Port-level checks for the file access stride predictor, bound to the top level.
module fasp_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_stall,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic signed [fasp_pkg::SCORE_W-1:0] score,
	input logic [fasp_pkg::STAT_W-1:0]        status
);
	import fasp_pkg::*;

	// one item at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("item accepted while previous one in flight");

	// no result can appear the cycle after an accept
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid |=> !out_valid)
		else $error("result appeared too early");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(score) && $stable(status))
		else $error("stalled result changed");

endmodule

bind file_access_stride_predictor_top fasp_checker u_fasp_checker (.*);

// ----- tb/tb_file_access_stride_predictor_top.sv -----
// Self-checking testbench for the file access stride predictor top level.
`timescale 1ns / 100ps

module tb_file_access_stride_predictor_top;
	import fasp_pkg::*;

	// block geometry at the default parameters
	localparam int PORTION_SHIFT   = PAGE_BYTES_LOG2_DEF + PORTION_PAGES_LOG2_DEF;
	// worst legal quiet stretch is the bitmap clear plus one long run, far below this
	localparam int WATCHDOG_CYCLES = 20000;
	localparam int RANDOM_PHASES   = 8;
	localparam int PHASE_ITEMS     = 175;

	// one result item as the block should report it
	typedef struct {
		logic signed [SCORE_W-1:0] score;
		logic [SPAGES_W-1:0]       stride_pages;
		logic [LEN_W-1:0]          strided_length;
		logic [STAT_W-1:0]         status;
	} stride_report_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic [OFF_W-1:0]           byte_offset = '0;
	logic [LEN_W-1:0]           byte_length = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic signed [SCORE_W-1:0]  score;
	logic [SPAGES_W-1:0]        stride_pages;
	logic [LEN_W-1:0]           strided_length;
	logic [STAT_W-1:0]          status;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index = '0;
	logic [CFG_DATA_W-1:0]      cfg_data = '0;

	file_access_stride_predictor_top u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.byte_offset    (byte_offset),
		.byte_length    (byte_length),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.score          (score),
		.stride_pages   (stride_pages),
		.strided_length (strided_length),
		.status         (status),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Mirror of the block: access bitmap, score and last stride, plus
	// the registers other than the start score, as last written.
	// ------------------------------------------------------------------
	bit          seen_portion [BITMAP_PORTIONS_DEF];
	int          seq_level;
	int          stride_portions;
	logic [31:0] stride_len;

	int          cfg_portions;
	int          cfg_depth;
	int          cfg_floor;
	int          cfg_ceil;

	stride_report_t pending_reports [$];
	int             n_errors;
	int             idle_cycles;

	// percentage knobs for the two sides
	int          sender_idle_pct;
	int          stall_pct;

	// traffic generator stream state
	int          stream_next;
	int          stream_step;

	// portions that can be marked: the file size clipped to the bitmap
	function automatic int map_limit();
		return (cfg_portions < BITMAP_PORTIONS_DEF) ? cfg_portions : BITMAP_PORTIONS_DEF;
	endfunction

	// Runs one request through the mirror and returns what the block should report.
	function automatic stride_report_t detect_stride(input logic [OFF_W-1:0] off,
			input logic [LEN_W-1:0] len);
		stride_report_t rpt;
		logic [STAT_W-1:0] st;
		int first, last, lim, depth, i, k;
		lim   = map_limit();
		depth = (cfg_depth > MAX_LOOKBACK_DEF) ? MAX_LOOKBACK_DEF : cfg_depth;
		first = int'(off >> PORTION_SHIFT);
		if (first >= lim) begin
			st = STAT_OOR;
		end else begin
			last = first + int'(len >> PORTION_SHIFT);
			if (last > lim - 1)
				last = lim - 1;
			for (i = first; i <= last; i++)
				seen_portion[i] = 1'b1;
			// depth zero falls straight through as not adjacent
			st = STAT_NOADJ;
			for (k = 1; k <= depth; k++) begin
				if (first < k) begin
					st = STAT_START;
					break;
				end
				if (seen_portion[first - k]) begin
					stride_portions = k - 1;
					if (k > 1)
						stride_len = len;
					st = STAT_ADJ;
					break;
				end
			end
			// limits apply as written, even when inverted
			if (st == STAT_ADJ)
				seq_level = (seq_level + 1 < cfg_ceil) ? seq_level + 1 : cfg_ceil;
			else if (st == STAT_NOADJ)
				seq_level = (seq_level - 1 > cfg_floor) ? seq_level - 1 : cfg_floor;
		end
		rpt.score          = seq_level[SCORE_W-1:0];
		rpt.stride_pages   = SPAGES_W'(stride_portions << PORTION_PAGES_LOG2_DEF);
		rpt.strided_length = stride_len;
		rpt.status         = st;
		return rpt;
	endfunction

	// ------------------------------------------------------------------
	// Drivers. Every task starts and ends at a falling edge.
	// ------------------------------------------------------------------
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_PORTION_COUNT:  cfg_portions = value;
			REG_LOOKBACK_DEPTH: cfg_depth    = value[DEPTH_W-1:0];
			REG_SCORE_MIN:      cfg_floor    = $signed(value[SMIN_W-1:0]);
			REG_SCORE_MAX:      cfg_ceil     = value[SMAX_W-1:0];
			// the start score also reloads the running score
			REG_SCORE_START:    seq_level    = $signed(value[SSTART_W-1:0]);
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Sends one item; valid is left high so back-to-back items need no gap.
	task automatic send_request(input logic [OFF_W-1:0] off, input logic [LEN_W-1:0] len);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid    = 1'b1;
		byte_offset = off;
		byte_length = len;
		do @(posedge clk); while (in_stall);
		pending_reports.push_back(detect_stride(off, len));
		@(negedge clk);
	endtask

	// Offset that lands in portion p, with random bytes inside the portion.
	function automatic logic [OFF_W-1:0] portion_offset(input int p);
		return (OFF_W'(p) << PORTION_SHIFT) | OFF_W'($urandom & 32'hFFFF);
	endfunction

	// Length spanning n further portions, random tail bytes.
	function automatic logic [LEN_W-1:0] portion_length(input int n);
		return (LEN_W'(n) << PORTION_SHIFT) | LEN_W'($urandom & 32'hFFFF);
	endfunction

	// Block is idle once every result is back; config writes only happen then.
	task automatic settle();
		in_valid = 1'b0;
		while (pending_reports.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Directed tests
	// ------------------------------------------------------------------

	// First hits from a clear map: lookback running off portion zero,
	// zero stride, nonzero stride, and a plain miss.
	task automatic test_adjacent_and_start();
		send_request(portion_offset(0), 32'd0);
		send_request(portion_offset(1), portion_length(0));
		send_request(portion_offset(3), portion_length(0));
		send_request(portion_offset(20), portion_length(0));
		send_request(portion_offset(5), portion_length(0));
		settle();
	endtask

	// Out of range by offset, clamping at the bitmap end and at a short file,
	// an empty file, and a file larger than the bitmap.
	task automatic test_range_edges();
		send_request({OFF_W{1'b1}}, {LEN_W{1'b1}});
		send_request(portion_offset(BITMAP_PORTIONS_DEF), 32'd0);
		send_request(portion_offset(BITMAP_PORTIONS_DEF - 1), {LEN_W{1'b1}});
		settle();
		write_reg(REG_PORTION_COUNT, 13'd100);
		send_request(portion_offset(100), portion_length(0));
		send_request(portion_offset(60), {LEN_W{1'b1}});
		send_request(portion_offset(99), portion_length(0));
		settle();
		write_reg(REG_PORTION_COUNT, 13'd0);
		send_request(portion_offset(0), 32'd0);
		settle();
		write_reg(REG_PORTION_COUNT, 13'h1FFF);
		send_request(portion_offset(BITMAP_PORTIONS_DEF - 1), portion_length(0));
		send_request(portion_offset(BITMAP_PORTIONS_DEF), portion_length(0));
		settle();
		write_reg(REG_PORTION_COUNT, PCNT_RST);
	endtask

	// Depth zero checks nothing; depth above the maximum acts as the maximum,
	// which reaches the widest stride; depth one only sees the neighbor.
	task automatic test_lookback_depth();
		write_reg(REG_LOOKBACK_DEPTH, 13'd0);
		send_request(portion_offset(200), portion_length(0));
		settle();
		write_reg(REG_LOOKBACK_DEPTH, 13'd15);
		send_request(portion_offset(208), portion_length(0));
		send_request(portion_offset(300), portion_length(0));
		send_request(portion_offset(309), portion_length(0));
		settle();
		write_reg(REG_LOOKBACK_DEPTH, 13'd1);
		send_request(portion_offset(311), portion_length(0));
		send_request(portion_offset(312), portion_length(0));
		settle();
		write_reg(REG_LOOKBACK_DEPTH, DEPTH_RST);
	endtask

	// Saturation at the widest limits, then limits written inverted.
	task automatic test_score_limits();
		write_reg(REG_SCORE_MAX, 13'd31);
		write_reg(REG_SCORE_START, 13'h1F);
		send_request(portion_offset(313), portion_length(0));
		settle();
		write_reg(REG_SCORE_MIN, 13'h10);
		write_reg(REG_SCORE_START, 13'h20);
		send_request(portion_offset(400), portion_length(0));
		settle();
		write_reg(REG_SCORE_MIN, 13'h0F);
		write_reg(REG_SCORE_MAX, 13'd0);
		write_reg(REG_SCORE_START, 13'd5);
		send_request(portion_offset(401), portion_length(0));
		send_request(portion_offset(420), portion_length(0));
		settle();
		write_reg(REG_SCORE_MIN, SMIN_RST);
		write_reg(REG_SCORE_MAX, SMAX_RST);
		write_reg(REG_SCORE_START, SSTART_RST);
	endtask

	// ------------------------------------------------------------------
	// Random traffic: mostly strided streams, plus scattered reads, long
	// runs to the map end, and full-width noise. Each phase picks new
	// registers and a new idling pattern.
	// ------------------------------------------------------------------
	task automatic test_random_traffic();
		int phase, j, roll, lim, p, v;
		logic [63:0] wide;
		logic [OFF_W-1:0] off;
		logic [LEN_W-1:0] len;
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			settle();
			case ($urandom_range(3))
				0: v = BITMAP_PORTIONS_DEF;
				1: v = 13'h1FFF;
				default: v = $urandom_range(BITMAP_PORTIONS_DEF, 64);
			endcase
			write_reg(REG_PORTION_COUNT, CFG_DATA_W'(v));
			case ($urandom_range(7))
				0: v = 0;
				1: v = $urandom_range(15, 9);
				default: v = $urandom_range(MAX_LOOKBACK_DEF, 1);
			endcase
			write_reg(REG_LOOKBACK_DEPTH, CFG_DATA_W'(v));
			v = -int'($urandom_range(16));
			write_reg(REG_SCORE_MIN, CFG_DATA_W'(v & 'h1F));
			write_reg(REG_SCORE_MAX, CFG_DATA_W'($urandom_range(16)));
			v = int'($urandom_range(32)) - 16;
			write_reg(REG_SCORE_START, CFG_DATA_W'(v & 'h3F));

			// idling pattern cycles through quiet, sender gaps, receiver stalls, both
			case (phase % 4)
				0: begin sender_idle_pct = 0;  stall_pct = 0;  end
				1: begin sender_idle_pct = 46; stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  stall_pct = 46; end
				default: begin sender_idle_pct = 13; stall_pct = 13; end
			endcase

			lim = map_limit();
			stream_next = lim;
			for (j = 0; j < PHASE_ITEMS; j++) begin
				roll = $urandom_range(99);
				if (roll < 5) begin
					// full-width noise, nearly always out of range
					wide = {$urandom, $urandom};
					off  = wide[OFF_W-1:0];
					len  = $urandom;
				end else if (roll < 8) begin
					// long run clamped at the end of the map
					p   = lim - 1 - $urandom_range((lim > 40) ? 40 : lim - 1);
					off = portion_offset(p);
					len = $urandom;
				end else if (roll < 25) begin
					p   = $urandom_range(lim - 1);
					off = portion_offset(p);
					len = portion_length($urandom_range(3));
				end else begin
					if (stream_next >= lim || $urandom_range(31) == 0) begin
						stream_next = $urandom_range(lim - 1);
						stream_step = $urandom_range(9, 1);
					end
					p   = stream_next;
					off = portion_offset(p);
					len = portion_length(($urandom_range(4) == 0) ? 1 : 0);
					stream_next = p + stream_step;
				end
				send_request(off, len);
			end
		end
		sender_idle_pct = 0;
		stall_pct = 0;
	endtask

	// ------------------------------------------------------------------
	// Result checker: every accepted result against the oldest prediction.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_results
		stride_report_t want;
		if (out_valid && !out_stall) begin
			if (pending_reports.size() == 0) begin
				$error("result item with no request outstanding: score %0d status %0d",
					score, status);
				n_errors++;
			end else begin
				want = pending_reports.pop_front();
				if (score !== want.score) begin
					$error("score: expected %0d, got %0d", want.score, score);
					n_errors++;
				end
				if (stride_pages !== want.stride_pages) begin
					$error("stride_pages: expected %0d, got %0d", want.stride_pages,
						stride_pages);
					n_errors++;
				end
				if (strided_length !== want.strided_length) begin
					$error("strided_length: expected 0x%08h, got 0x%08h",
						want.strided_length, strided_length);
					n_errors++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					n_errors++;
				end
			end
		end
	end

	// receiver stall, redrawn every cycle
	always @(negedge clk)
		out_stall = ($urandom_range(99) < stall_pct);

	// watchdog: too long without any handshake on any channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles == WATCHDOG_CYCLES) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		// mirror state after reset: clear map, registers at reset values
		foreach (seen_portion[i])
			seen_portion[i] = 1'b0;
		cfg_portions    = PCNT_RST;
		cfg_depth       = DEPTH_RST;
		cfg_floor       = $signed(SMIN_RST);
		cfg_ceil        = SMAX_RST;
		seq_level       = $signed(SSTART_RST);
		stride_portions = 0;
		stride_len      = '0;
		n_errors        = 0;
		idle_cycles     = 0;
		sender_idle_pct = 0;
		stall_pct       = 0;

		// single reset at the start; the block then clears its map on its own
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		test_adjacent_and_start();
		test_range_edges();
		test_lookback_depth();
		test_score_limits();
		test_random_traffic();

		// drain, then leave room for any stray extra result to show up
		settle();
		repeat (300) @(negedge clk);
		if (n_errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- file_access_stride_predictor_top.f -----
sv/fasp_pkg.sv
sv/fasp_bitmap.sv
sv/file_access_stride_predictor_top.sv
sv/fasp_checker.sv
tb/tb_file_access_stride_predictor_top.sv
